// ===== src/rc2mcc_pkg.sv =====
// Shared types, codes and the fixed bit routing table for the report-to-CC converter.
package rc2mcc_pkg;

  // Controller states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EVAL,
    ST_EMIT
  } state_t;

  // Configuration register indexes
  typedef enum logic [1:0] {
    CFG_BASE_CHANNEL    = 2'd0,
    CFG_CHANGE_DEADZONE = 2'd1,
    CFG_VIEW_MODE       = 2'd2
  } cfg_index_t;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 7;

  // View mode codes
  localparam logic [1:0] VIEW_BYTE = 2'd0;
  localparam logic [1:0] VIEW_BIT  = 2'd1;
  localparam logic [1:0] VIEW_BOTH = 2'd2;

  // Bit view values
  localparam logic [6:0] CC_ON  = 7'h7F;
  localparam logic [6:0] CC_OFF = 7'h00;

  // Fixed routes all land on channel zero
  localparam logic [3:0] ROUTE_CHANNEL = 4'd0;

  // Controller to datapath commands
  typedef struct packed {
    logic accept;  // input transfer: read and write the store, latch the byte
    logic eval;    // compare against the stored byte, arm pending messages
    logic load;    // move the next pending message into the output register
  } dp_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic pending;    // evaluation found at least one message
    logic slot_free;  // output register can take a message this cycle
    logic last;       // the message offered now is the final one for this byte
  } dp_status_t;

  typedef struct packed {
    logic       hit;
    logic [6:0] ctl;
  } bit_route_t;

  // Fixed routing of individual bits to controllers 20 to 24
  function automatic bit_route_t route_bit(logic [7:0] pos, logic [2:0] bit_idx);
    bit_route_t r;
    r.hit = 1'b1;
    r.ctl = 7'd0;
    case ({pos, bit_idx})
      {8'd4, 3'd7}: r.ctl = 7'd20;
      {8'd4, 3'd5}: r.ctl = 7'd21;
      {8'd4, 3'd3}: r.ctl = 7'd22;
      {8'd4, 3'd1}: r.ctl = 7'd23;
      {8'd7, 3'd3}: r.ctl = 7'd24;
      default:      r.hit = 1'b0;
    endcase
    return r;
  endfunction

endpackage

// ===== src/report_change_to_midi_cc.sv =====
// The first message of a byte reaches the output register after the accept, evaluation and emit states.
// A byte passes the accept and evaluation states, then issues one message a cycle (up to 9) while the
// output register is free, set by the registered store read and the single output register.
// A new byte is taken while the last message of the previous byte still waits on the output.
// Reset clears the position, previous length, baseline flag, configuration and output valid;
// the report store is not cleared, as only entries written by the last report are compared.
module report_change_to_midi_cc #(
  parameter int MAX_REPORT_BYTES = 256
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [rc2mcc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [rc2mcc_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [7:0]                        in_report_byte,
  input  logic                              in_end_of_report,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [3:0]                        out_midi_channel,
  output logic [6:0]                        out_controller_number,
  output logic [6:0]                        out_cc_value,
  output logic                              out_last_of_run
);
  import rc2mcc_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  // Sequence control
  rc2mcc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  // Store, compare and message generation
  rc2mcc_dp #(
    .MAX_REPORT_BYTES (MAX_REPORT_BYTES)
  ) u_dp (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .cfg_we                (cfg_we),
    .cfg_index             (cfg_index),
    .cfg_wdata             (cfg_wdata),
    .in_report_byte        (in_report_byte),
    .in_end_of_report      (in_end_of_report),
    .out_stall             (out_stall),
    .cmd                   (cmd),
    .status                (status),
    .out_valid             (out_valid),
    .out_midi_channel      (out_midi_channel),
    .out_controller_number (out_controller_number),
    .out_cc_value          (out_cc_value),
    .out_last_of_run       (out_last_of_run)
  );

endmodule

// ===== src/rc2mcc_ram.sv =====
// Generic single-write, single-read RAM with registered read data (read-first).
module rc2mcc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write and read in the same cycle; a read of the written entry returns old data
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== src/rc2mcc_ctrl.sv =====
// Controller state machine: accept a byte, evaluate it, then issue its messages.
module rc2mcc_ctrl (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  rc2mcc_pkg::dp_status_t status,
  output rc2mcc_pkg::dp_cmd_t    cmd
);
  import rc2mcc_pkg::*;

  state_t state_r;
  state_t state_nxt;

  // Hold state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Advance state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) state_nxt = ST_EVAL;
      end
      ST_EVAL: begin
        state_nxt = status.pending ? ST_EMIT : ST_IDLE;
      end
      ST_EMIT: begin
        if (status.slot_free && status.last) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Drive commands
  always_comb begin
    in_stall   = 1'b1;
    cmd.accept = 1'b0;
    cmd.eval   = 1'b0;
    cmd.load   = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_stall   = 1'b0;
        cmd.accept = in_valid;
      end
      ST_EVAL: begin
        cmd.eval = 1'b1;
      end
      ST_EMIT: begin
        cmd.load = status.slot_free;
      end
      default: begin
        in_stall = 1'b1;
      end
    endcase
  end

endmodule

// ===== src/rc2mcc_dp.sv =====
// Datapath: configuration, report store, change detection and message output register.
module rc2mcc_dp #(
  parameter int MAX_REPORT_BYTES = 256
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [rc2mcc_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [rc2mcc_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  input  logic [7:0]                          in_report_byte,
  input  logic                                in_end_of_report,
  input  logic                                out_stall,
  input  rc2mcc_pkg::dp_cmd_t                 cmd,
  output rc2mcc_pkg::dp_status_t              status,
  output logic                                out_valid,
  output logic [3:0]                          out_midi_channel,
  output logic [6:0]                          out_controller_number,
  output logic [6:0]                          out_cc_value,
  output logic                                out_last_of_run
);
  import rc2mcc_pkg::*;

  localparam int AW = $clog2(MAX_REPORT_BYTES);
  localparam int PW = $clog2(MAX_REPORT_BYTES + 1);
  localparam logic [PW-1:0] POS_MAX = PW'(MAX_REPORT_BYTES);

  // Configuration registers
  logic [3:0] base_channel_r;
  logic [6:0] deadzone_r;
  logic [1:0] view_mode_r;

  // Report tracking
  logic [PW-1:0] pos_r, pos_nxt;
  logic [PW-1:0] prev_len_r;
  logic          baseline_r;
  logic          in_range;
  logic [PW-1:0] count;

  // Current item
  logic [AW-1:0] item_pos_r;
  logic [7:0]    cur_r;
  logic          active_r;
  logic [7:0]    prev_q;

  // Pending messages
  logic       pend_byte_r;
  logic [7:0] mask_r;

  // Output register
  logic       out_valid_r, out_valid_nxt;
  logic [3:0] out_ch_r;
  logic [6:0] out_ctl_r;
  logic [6:0] out_val_r;
  logic       out_last_r;

  // Evaluation and message selection
  logic [7:0] diff;
  logic [6:0] pv, cv, delta;
  logic       byte_on;
  logic [7:0] bit_mask;
  logic [2:0] low_bit;
  logic [7:0] mask_rest;
  logic [7:0] pos8;
  bit_route_t route;
  logic [3:0] msg_ch;
  logic [6:0] msg_ctl;
  logic [6:0] msg_val;
  logic       msg_last;

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_channel_r <= 4'd0;
      deadzone_r     <= 7'd0;
      view_mode_r    <= VIEW_BOTH;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_BASE_CHANNEL:    base_channel_r <= cfg_wdata[3:0];
        CFG_CHANGE_DEADZONE: deadzone_r     <= cfg_wdata[6:0];
        CFG_VIEW_MODE:       view_mode_r    <= cfg_wdata[1:0];
        default:             ;
      endcase
    end
  end

  // Saturate the position at the store depth
  assign in_range = (pos_r < POS_MAX);
  assign count    = in_range ? pos_r + PW'(1) : pos_r;
  assign pos_nxt  = in_end_of_report ? '0 : count;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r      <= '0;
      prev_len_r <= '0;
      baseline_r <= 1'b0;
    end else if (cmd.accept) begin
      pos_r <= pos_nxt;
      if (in_end_of_report) begin
        prev_len_r <= count;
        baseline_r <= 1'b1;
      end
    end
  end

  // Latch the item; compare rights are decided against the state before this byte
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      item_pos_r <= pos_r[AW-1:0];
      cur_r      <= in_report_byte;
      active_r   <= baseline_r && (pos_r < prev_len_r) && in_range;
    end
  end

  // Previous report store
  rc2mcc_ram #(
    .WIDTH (8),
    .DEPTH (MAX_REPORT_BYTES)
  ) u_store (
    .clk   (clk),
    .we    (cmd.accept && in_range),
    .waddr (pos_r[AW-1:0]),
    .wdata (in_report_byte),
    .raddr (pos_r[AW-1:0]),
    .rdata (prev_q)
  );

  // Detect the change and decide which views fire
  always_comb begin
    diff     = prev_q ^ cur_r;
    pv       = prev_q[7:1];
    cv       = cur_r[7:1];
    delta    = (pv > cv) ? (pv - cv) : (cv - pv);
    byte_on  = active_r && ((view_mode_r == VIEW_BYTE) || (view_mode_r == VIEW_BOTH)) &&
               (delta > deadzone_r);
    bit_mask = (active_r && ((view_mode_r == VIEW_BIT) || (view_mode_r == VIEW_BOTH))) ?
               diff : 8'd0;
  end

  assign status.pending = byte_on || (bit_mask != 8'd0);

  // Pick the lowest flipped bit still pending
  always_comb begin
    low_bit = 3'd0;
    for (int i = 7; i >= 0; i--) begin
      if (mask_r[i]) low_bit = 3'(i);
    end
  end

  assign mask_rest = mask_r & (mask_r - 8'd1);
  assign pos8      = 8'(item_pos_r);
  assign route     = route_bit(pos8, low_bit);

  // Build the next message: byte view first, then bits in ascending order
  always_comb begin
    if (pend_byte_r) begin
      msg_ch   = base_channel_r + {3'b000, pos8[7]};
      msg_ctl  = pos8[6:0];
      msg_val  = cur_r[7:1];
      msg_last = (mask_r == 8'd0);
    end else begin
      if (route.hit) begin
        msg_ch  = ROUTE_CHANNEL;
        msg_ctl = route.ctl;
      end else begin
        msg_ch  = base_channel_r + pos8[7:4];
        msg_ctl = {pos8[3:0], low_bit};
      end
      msg_val  = cur_r[low_bit] ? CC_ON : CC_OFF;
      msg_last = (mask_rest == 8'd0);
    end
  end

  assign status.last      = msg_last;
  assign status.slot_free = !out_valid_r || !out_stall;

  // Arm and drain the pending messages
  always_ff @(posedge clk) begin
    if (cmd.eval) begin
      pend_byte_r <= byte_on;
      mask_r      <= bit_mask;
    end else if (cmd.load) begin
      if (pend_byte_r) begin
        pend_byte_r <= 1'b0;
      end else begin
        mask_r <= mask_rest;
      end
    end
  end

  // Output register
  assign out_valid_nxt = cmd.load ? 1'b1 : (out_valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      out_ch_r   <= msg_ch;
      out_ctl_r  <= msg_ctl;
      out_val_r  <= msg_val;
      out_last_r <= msg_last;
    end
  end

  assign out_valid             = out_valid_r;
  assign out_midi_channel      = out_ch_r;
  assign out_controller_number = out_ctl_r;
  assign out_cc_value          = out_val_r;
  assign out_last_of_run       = out_last_r;

endmodule

// ===== src/rc2mcc_chk.sv =====
// Port-level checker for the report-to-CC converter and its bind to the top level.
module rc2mcc_chk (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic [3:0] out_midi_channel,
  input logic [6:0] out_controller_number,
  input logic [6:0] out_cc_value,
  input logic       out_last_of_run
);

  // A stalled message holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_midi_channel) &&
      $stable(out_controller_number) && $stable(out_cc_value) && $stable(out_last_of_run))
    else $error("stalled output message changed");

  // An input transfer is followed by a busy cycle for evaluation
  a_busy_after_in: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken again right after a transfer");

  // A run continues without a gap once a non-final message is taken
  a_run_no_gap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && !out_last_of_run |=> out_valid)
    else $error("gap inside a message run");

  // While a run is unfinished no new byte is taken
  a_run_blocks_in: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last_of_run |-> in_stall)
    else $error("input open during an unfinished run");

endmodule

bind report_change_to_midi_cc rc2mcc_chk u_rc2mcc_chk (.*);

// ===== test/report_change_to_midi_cc_test.sv =====
// Self-checking testbench for the report change to MIDI CC converter.
module report_change_to_midi_cc_test;
  timeunit 1ns;
  timeprecision 1ps;

  import rc2mcc_pkg::*;

  localparam int STORE_DEPTH   = 256;
  localparam int SETTLE_CYCLES = 16;
  localparam int RANDOM_BYTES  = 30;
  localparam longint LIMIT_NS  = 10_000_000;

  // Register index with no register behind it, and the mode that sends nothing
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_INDEX = 2'd3;
  localparam logic [1:0]           VIEW_NONE        = 2'd3;

  typedef struct packed {
    logic [3:0] channel;
    logic [6:0] controller;
    logic [6:0] value;
    logic       last;
  } cc_msg_t;

  logic                  clk;
  logic                  rst_n            = 1'b0;
  logic                  cfg_we           = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index        = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata        = '0;
  logic                  in_valid         = 1'b0;
  logic                  in_stall;
  logic [7:0]            in_report_byte   = '0;
  logic                  in_end_of_report = 1'b0;
  logic                  out_valid;
  logic                  out_stall        = 1'b0;
  logic [3:0]            out_midi_channel;
  logic [6:0]            out_controller_number;
  logic [6:0]            out_cc_value;
  logic                  out_last_of_run;

  // Shadow of the converter: stored report, position and registers
  logic [7:0] stored_report [STORE_DEPTH];
  bit         baseline_seen = 1'b0;
  logic [8:0] stored_len    = '0;
  logic [8:0] next_pos      = '0;
  logic [3:0] base_ch_q     = 4'd0;
  logic [6:0] deadzone_q    = 7'd0;
  logic [1:0] view_q        = VIEW_BOTH;

  cc_msg_t cc_expected [$];

  bit gaps_on   = 1'b1;
  bit stalls_on = 1'b1;
  int stall_run = 0;
  int errors    = 0;
  int bytes_sent = 0, reports_sent = 0, msgs_checked = 0, reg_writes = 0;

  report_change_to_midi_cc #(.MAX_REPORT_BYTES(STORE_DEPTH)) dut (
    .clk, .rst_n, .cfg_we, .cfg_index, .cfg_wdata,
    .in_valid, .in_stall, .in_report_byte, .in_end_of_report,
    .out_valid, .out_stall, .out_midi_channel, .out_controller_number,
    .out_cc_value, .out_last_of_run
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #(LIMIT_NS);
    $display("%0t: timeout, %0d messages still expected", $time, cc_expected.size());
    $display("report_change_to_midi_cc_test NOT OK");
    $finish;
  end

  // Mostly short gaps, a few long ones
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(12, 30);
  endfunction

  // Work out the messages that one report byte causes, then advance the shadow
  task automatic predict_byte(input logic [7:0] data, input logic last);
    cc_msg_t    run [9];
    cc_msg_t    m;
    int         n;
    logic [7:0] old;
    logic [7:0] flipped;
    logic [6:0] delta;
    logic [11:0] k;
    logic [8:0] count;
    bit         routed;
    n = 0;
    count = next_pos;
    if (next_pos < STORE_DEPTH) begin
      old = stored_report[next_pos[7:0]];
      if (baseline_seen && next_pos < stored_len && old != data) begin
        flipped = old ^ data;
        delta = (old[7:1] > data[7:1]) ? old[7:1] - data[7:1] : data[7:1] - old[7:1];
        // byte view leads
        if ((view_q == VIEW_BYTE || view_q == VIEW_BOTH) && delta > deadzone_q) begin
          m.channel    = base_ch_q + 4'(next_pos >> 7);
          m.controller = next_pos[6:0];
          m.value      = data[7:1];
          m.last       = 1'b0;
          run[n] = m;
          n++;
        end
        // bit view: one message per flipped bit, lowest bit first
        if (view_q == VIEW_BIT || view_q == VIEW_BOTH) begin
          for (int b = 0; b < 8; b++) begin
            if (flipped[b]) begin
              m.value = data[b] ? CC_ON : CC_OFF;
              m.last  = 1'b0;
              routed  = 1'b1;
              case ({next_pos, 3'(b)})
                {9'd4, 3'd7}: m.controller = 7'd20;
                {9'd4, 3'd5}: m.controller = 7'd21;
                {9'd4, 3'd3}: m.controller = 7'd22;
                {9'd4, 3'd1}: m.controller = 7'd23;
                {9'd7, 3'd3}: m.controller = 7'd24;
                default:      routed = 1'b0;
              endcase
              if (routed) begin
                m.channel = ROUTE_CHANNEL;
              end else begin
                k = {next_pos, 3'(b)};
                m.channel    = base_ch_q + 4'(k >> 7);
                m.controller = k[6:0];
              end
              run[n] = m;
              n++;
            end
          end
        end
      end
      stored_report[next_pos[7:0]] = data;
      count = next_pos + 9'd1;
    end
    for (int i = 0; i < n; i++) begin
      m = run[i];
      m.last = (i == n - 1);
      cc_expected = {cc_expected, m};
    end
    if (last) begin
      stored_len    = count;
      baseline_seen = 1'b1;
      next_pos      = '0;
    end else begin
      next_pos = count;
    end
  endtask

  // Offer one byte after a random gap and hold it until the transfer
  task automatic send_byte(input logic [7:0] data, input logic last);
    int gap;
    gap = gaps_on ? pick_gap() : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid         <= 1'b1;
    in_report_byte   <= data;
    in_end_of_report <= last;
    do @(posedge clk); while (in_stall);
    predict_byte(data, last);
    bytes_sent++;
    if (last) reports_sent++;
  endtask

  // Drop valid, drain every expected message, then let the pipeline settle
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (cc_expected.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write one register; only called while the converter is idle
  task automatic set_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    case (idx)
      CFG_BASE_CHANNEL:    base_ch_q  = data[3:0];
      CFG_CHANGE_DEADZONE: deadzone_q = data;
      CFG_VIEW_MODE:       view_q     = data[1:0];
      default: ;
    endcase
    reg_writes++;
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // Next byte of a report: mostly the stored byte or a few flips of it
  function automatic logic [7:0] pick_report_byte(input int keep_pct);
    logic [7:0] old;
    int         r;
    if (baseline_seen && next_pos < stored_len) old = stored_report[next_pos[7:0]];
    else old = 8'($urandom);
    r = $urandom_range(0, 99);
    if (r < keep_pct) return old;
    r = $urandom_range(0, 99);
    if (r < 45) return old ^ (8'h01 << $urandom_range(0, 7));
    if (r < 70) return old ^ 8'($urandom);
    if (r < 80) return ~old;
    if (r < 90) return $urandom_range(0, 1) ? 8'hFF : 8'h00;
    return 8'($urandom);
  endfunction

  task automatic send_report(input int len, input int keep_pct);
    for (int i = 0; i < len; i++) send_byte(pick_report_byte(keep_pct), i == len - 1);
  endtask

  // Check each transferred message against the oldest expectation
  always @(posedge clk) begin
    cc_msg_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (cc_expected.size() == 0) begin
        $display("%0t: unexpected message ch=%0d ctl=%0d val=%0d last=%0b", $time,
                 out_midi_channel, out_controller_number, out_cc_value, out_last_of_run);
        errors++;
      end else begin
        want = cc_expected.pop_front();
        msgs_checked++;
        if (out_midi_channel !== want.channel) begin
          $display("%0t: channel expected %0d got %0d", $time, want.channel, out_midi_channel);
          errors++;
        end
        if (out_controller_number !== want.controller) begin
          $display("%0t: controller expected %0d got %0d", $time, want.controller,
                   out_controller_number);
          errors++;
        end
        if (out_cc_value !== want.value) begin
          $display("%0t: value expected %0d got %0d", $time, want.value, out_cc_value);
          errors++;
        end
        if (out_last_of_run !== want.last) begin
          $display("%0t: last expected %0b got %0b", $time, want.last, out_last_of_run);
          errors++;
        end
      end
    end
    // stall the result side in random runs
    if (!stalls_on) begin
      out_stall <= 1'b0;
    end else if (stall_run > 0) begin
      stall_run--;
      out_stall <= 1'b1;
    end else begin
      stall_run = pick_gap();
      out_stall <= (stall_run > 0);
      if (stall_run > 0) stall_run--;
    end
  end

  // Reset defaults: baseline, extreme bytes, fixed routes, longer and shorter reports
  task automatic test_first_reports();
    logic [7:0] baseline [8];
    logic [7:0] second [9];
    baseline = '{8'h00, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00};
    second   = '{8'hFF, 8'hFF, 8'h01, 8'h80, 8'hAA, 8'h7F, 8'h00, 8'h08, 8'h55};
    // first report only becomes the baseline
    foreach (baseline[i]) send_byte(baseline[i], i == 7);
    // all bits flipped, unchanged, below deadzone, fixed routes, beyond previous length
    foreach (second[i]) send_byte(second[i], i == 8);
    // shorter report with a deadzone change in the middle
    send_byte(8'h00, 1'b0);
    send_byte(8'hFE, 1'b0);
    wait_idle();
    set_reg(CFG_CHANGE_DEADZONE, 7'd127);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h80, 1'b0);
    send_byte(8'h55, 1'b1);
    wait_idle();
  endtask

  // Long reports: positions past the store depth, channel offsets and wrap
  task automatic test_store_depth();
    set_reg(CFG_BASE_CHANNEL, 7'd15);
    set_reg(CFG_CHANGE_DEADZONE, 7'd0);
    set_reg(CFG_VIEW_MODE, {5'd0, VIEW_BOTH});
    send_report(STORE_DEPTH + 1, 50);
    send_report(132, 85);
    wait_idle();
  endtask

  // Random register settings, each followed by a few random reports
  task automatic test_random_reports();
    int start_bytes;
    int phase;
    int len;
    int keep_pct;
    start_bytes = bytes_sent;
    phase = 0;
    while (bytes_sent - start_bytes < RANDOM_BYTES) begin
      wait_idle();
      gaps_on   = (phase % 5 != 2) && ($urandom_range(0, 3) != 0);
      stalls_on = (phase % 5 != 2) && ($urandom_range(0, 3) != 0);
      case ($urandom_range(0, 3))
        0:       set_reg(CFG_BASE_CHANNEL, {3'($urandom), 4'd0});
        1:       set_reg(CFG_BASE_CHANNEL, {3'($urandom), 4'd15});
        default: set_reg(CFG_BASE_CHANNEL, 7'($urandom));
      endcase
      case ($urandom_range(0, 4))
        0:       set_reg(CFG_CHANGE_DEADZONE, 7'd0);
        1:       set_reg(CFG_CHANGE_DEADZONE, 7'd127);
        2:       set_reg(CFG_CHANGE_DEADZONE, 7'($urandom));
        default: set_reg(CFG_CHANGE_DEADZONE, 7'($urandom_range(0, 6)));
      endcase
      case ($urandom_range(0, 9))
        0, 1, 2: set_reg(CFG_VIEW_MODE, {5'($urandom), VIEW_BYTE});
        3, 4, 5: set_reg(CFG_VIEW_MODE, {5'($urandom), VIEW_BIT});
        6, 7, 8: set_reg(CFG_VIEW_MODE, {5'($urandom), VIEW_BOTH});
        default: set_reg(CFG_VIEW_MODE, {5'($urandom), VIEW_NONE});
      endcase
      if (phase == 0 || $urandom_range(0, 7) == 0) set_reg(CFG_UNUSED_INDEX, 7'($urandom));
      keep_pct = $urandom_range(30, 85);
      repeat ($urandom_range(2, 5)) begin
        case ($urandom_range(0, 9))
          0, 1, 2, 3, 4, 5: len = $urandom_range(1, 10);
          6, 7:             len = $urandom_range(8, 16);
          8:                len = (stored_len > 0) ? int'(stored_len) : 8;
          default:          len = $urandom_range(17, 40);
        endcase
        send_report(len, keep_pct);
      end
      phase++;
    end
    wait_idle();
    gaps_on   = 1'b1;
    stalls_on = 1'b1;
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    test_first_reports();
    test_store_depth();
    test_random_reports();
    wait_idle();
    $display("Sent %0d report bytes in %0d reports with %0d register writes,", bytes_sent,
             reports_sent, reg_writes);
    $display("checked %0d CC messages across byte, bit, both and silent views.", msgs_checked);
    if (errors == 0) begin
      $display("report_change_to_midi_cc_test OK");
    end else begin
      $display("report_change_to_midi_cc_test NOT OK");
    end
    $finish;
  end

endmodule

// ===== files.f =====
src/rc2mcc_pkg.sv
src/rc2mcc_ram.sv
src/rc2mcc_ctrl.sv
src/rc2mcc_dp.sv
src/report_change_to_midi_cc.sv
src/rc2mcc_chk.sv
test/report_change_to_midi_cc_test.sv
